@@ rtl/core/acalc_pkg.sv @@
// Shared constants and types for the ASCII infix integer calculator.
package acalc_pkg;

   localparam int ACALC_WORD_BITS = 32;
   localparam int OUT_BITS        = 32;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_BAD_OP   = 2'd2;
   localparam logic [1:0] ST_QUIT     = 2'd3;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_Q_UP   = 8'h51;
   localparam logic [7:0] CH_Q_LOW  = 8'h71;

   typedef struct packed {
      logic [1:0] status;
      logic [1:0] opcode;
   } acalc_ctl_type;

endpackage

@@ rtl/core/acalc_req_if.sv @@
// Input channel carrying one character or an end-of-line marker per item.
interface acalc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_line;

   modport source (output valid, output char_code, output end_of_line, input ready);
   modport sink (input valid, input char_code, input end_of_line, output ready);
endinterface

@@ rtl/core/acalc_rsp_if.sv @@
// Result channel carrying one calculation result per item.
interface acalc_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [1:0]         operator_code;
   logic signed [31:0] first_operand;
   logic signed [31:0] second_operand;
   logic signed [31:0] answer;
   logic signed [31:0] remainder_value;

   modport source (output valid, output status, output operator_code,
                   output first_operand, output second_operand, output answer,
                   output remainder_value, input ready);
   modport sink (input valid, input status, input operator_code,
                 input first_operand, input second_operand, input answer,
                 input remainder_value, output ready);
endinterface

@@ rtl/core/acalc_parser.sv @@
// Character parser that builds the operands and operator of one line.
module acalc_parser #(
   parameter int WORD_BITS = acalc_pkg::ACALC_WORD_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    char_take,
   input  logic                    line_end,
   input  logic [7:0]              char_code,
   output acalc_pkg::acalc_ctl_type job_ctl,
   output logic [WORD_BITS-1:0]    job_a,
   output logic [WORD_BITS-1:0]    job_b
);
   import acalc_pkg::*;

   localparam logic [3:0] PH_START     = 4'd0;
   localparam logic [3:0] PH_N1_SIGN   = 4'd1;
   localparam logic [3:0] PH_N1_AFTER  = 4'd2;
   localparam logic [3:0] PH_N1_DIGITS = 4'd3;
   localparam logic [3:0] PH_OPWAIT    = 4'd4;
   localparam logic [3:0] PH_BADOP     = 4'd5;
   localparam logic [3:0] PH_QUIT      = 4'd6;
   localparam logic [3:0] PH_N2_START  = 4'd7;
   localparam logic [3:0] PH_N2_SIGN   = 4'd8;
   localparam logic [3:0] PH_N2_AFTER  = 4'd9;
   localparam logic [3:0] PH_N2_DIGITS = 4'd10;
   localparam logic [3:0] PH_DONE      = 4'd11;

   logic [3:0]           phase_ff, phase_in;
   logic [WORD_BITS-1:0] first_ff, first_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic                 neg_ff, neg_in;
   logic [1:0]           opr_ff, opr_in;

   logic                 go;
   logic                 do_add;
   logic                 is_blank;
   logic                 is_digit;
   logic [WORD_BITS-1:0] finished;
   logic [WORD_BITS-1:0] acc_var;
   logic [WORD_BITS-1:0] digit_ext;

   assign is_blank  = (char_code == CH_SPACE) || (char_code == CH_TAB);
   assign is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign finished  = neg_ff ? (~acc_ff + 1'b1) : acc_ff;
   assign digit_ext = WORD_BITS'(char_code[3:0]);

   always_comb begin
      go       = 1'b1;
      do_add   = 1'b0;
      phase_in = phase_ff;
      first_in = first_ff;
      acc_var  = acc_ff;
      neg_in   = neg_ff;
      opr_in   = opr_ff;

      if (phase_in == PH_START) begin
         if (is_blank) begin
            go = 1'b0;
         end else if (char_code == CH_Q_LOW || char_code == CH_Q_UP
                      || char_code == CH_NUL) begin
            phase_in = PH_QUIT;
            go       = 1'b0;
         end else begin
            acc_var  = '0;
            neg_in   = 1'b0;
            phase_in = PH_N1_SIGN;
         end
      end
      if (go && phase_in == PH_N1_SIGN) begin
         phase_in = PH_N1_AFTER;
         if (char_code == CH_MINUS) begin
            neg_in = 1'b1;
            go     = 1'b0;
         end else if (char_code == CH_PLUS) begin
            go = 1'b0;
         end
      end
      if (go && phase_in == PH_N1_AFTER) begin
         if (is_digit) begin
            do_add   = 1'b1;
            phase_in = PH_N1_DIGITS;
            go       = 1'b0;
         end else begin
            first_in = '0;
            phase_in = PH_OPWAIT;
         end
      end
      if (go && phase_in == PH_N1_DIGITS) begin
         if (is_digit) begin
            do_add = 1'b1;
            go     = 1'b0;
         end else begin
            first_in = finished;
            phase_in = PH_OPWAIT;
         end
      end
      if (go && phase_in == PH_OPWAIT) begin
         go = 1'b0;
         if (!is_blank) begin
            phase_in = PH_N2_START;
            acc_var  = '0;
            neg_in   = 1'b0;
            case (char_code)
               CH_PLUS:  opr_in = OP_ADD;
               CH_MINUS: opr_in = OP_SUB;
               CH_STAR:  opr_in = OP_MUL;
               CH_SLASH: opr_in = OP_DIV;
               default: begin
                  phase_in = PH_BADOP;
                  acc_var  = acc_ff;
                  neg_in   = neg_ff;
               end
            endcase
         end
      end
      if (go && phase_in == PH_N2_START) begin
         if (is_blank) begin
            go = 1'b0;
         end else begin
            phase_in = PH_N2_SIGN;
         end
      end
      if (go && phase_in == PH_N2_SIGN) begin
         phase_in = PH_N2_AFTER;
         if (char_code == CH_MINUS) begin
            neg_in = 1'b1;
            go     = 1'b0;
         end else if (char_code == CH_PLUS) begin
            go = 1'b0;
         end
      end
      if (go && phase_in == PH_N2_AFTER) begin
         go = 1'b0;
         if (is_digit) begin
            do_add   = 1'b1;
            phase_in = PH_N2_DIGITS;
         end else begin
            acc_var  = '0;
            neg_in   = 1'b0;
            phase_in = PH_DONE;
         end
      end
      if (go && phase_in == PH_N2_DIGITS) begin
         if (!is_digit) begin
            acc_var  = finished;
            neg_in   = 1'b0;
            phase_in = PH_DONE;
         end else begin
            do_add = 1'b1;
         end
      end

      if (do_add) begin
         acc_in = (acc_var << 3) + (acc_var << 1) + digit_ext;
      end else begin
         acc_in = acc_var;
      end
   end

   always_comb begin
      job_ctl.status = ST_OK;
      job_ctl.opcode = OP_ADD;
      job_a          = '0;
      job_b          = '0;
      unique case (phase_ff)
         PH_START, PH_QUIT: begin
            job_ctl.status = ST_QUIT;
         end
         PH_N1_SIGN, PH_N1_AFTER, PH_N1_DIGITS: begin
            job_ctl.status = ST_BAD_OP;
            job_a          = finished;
         end
         PH_OPWAIT, PH_BADOP: begin
            job_ctl.status = ST_BAD_OP;
            job_a          = first_ff;
         end
         default: begin
            job_ctl.opcode = opr_ff;
            job_a          = first_ff;
            job_b          = finished;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || line_end) begin
         phase_ff <= PH_START;
         first_ff <= '0;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         opr_ff   <= OP_ADD;
      end else if (char_take) begin
         phase_ff <= phase_in;
         first_ff <= first_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         opr_ff   <= opr_in;
      end
   end

endmodule

@@ rtl/core/acalc_alu.sv @@
// Sequenced arithmetic unit around one shared adder for add, multiply and divide.
module acalc_alu #(
   parameter int WORD_BITS = acalc_pkg::ACALC_WORD_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  acalc_pkg::acalc_ctl_type in_ctl,
   input  logic [WORD_BITS-1:0]     in_a,
   input  logic [WORD_BITS-1:0]     in_b,
   output logic                     idle,
   output logic                     res_valid,
   input  logic                     res_take,
   output acalc_pkg::acalc_ctl_type res_ctl,
   output logic [WORD_BITS-1:0]     res_a,
   output logic [WORD_BITS-1:0]     res_b,
   output logic [WORD_BITS-1:0]     res_ans,
   output logic [WORD_BITS-1:0]     res_rem
);
   import acalc_pkg::*;

   localparam int CNT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ADDSUB = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_ABSA   = 3'd3;
   localparam logic [2:0] S_ABSB   = 3'd4;
   localparam logic [2:0] S_DIV    = 3'd5;
   localparam logic [2:0] S_FIX    = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]           state_ff, state_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] x_ff, x_in;
   logic [WORD_BITS-1:0] y_ff, y_in;
   logic [WORD_BITS-1:0] z_ff, z_in;
   logic                 na_ff, na_in;
   logic                 nb_ff, nb_in;
   logic                 fixq_ff, fixq_in;
   acalc_ctl_type        ctl_ff, ctl_in;
   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [WORD_BITS-1:0] b_ff, b_in;

   logic [WORD_BITS-1:0] add_p;
   logic [WORD_BITS-1:0] add_q;
   logic                 add_sub;
   logic [WORD_BITS:0]   add_sum;
   logic [WORD_BITS-1:0] rem_shift;

   assign rem_shift = {x_ff[WORD_BITS-2:0], z_ff[WORD_BITS-1]};

   always_comb begin
      add_p   = x_ff;
      add_q   = y_ff;
      add_sub = 1'b0;
      unique case (state_ff)
         S_ADDSUB: add_sub = (ctl_ff.opcode == OP_SUB);
         S_ABSA: begin
            add_p   = '0;
            add_q   = z_ff;
            add_sub = 1'b1;
         end
         S_ABSB: begin
            add_p   = '0;
            add_q   = y_ff;
            add_sub = 1'b1;
         end
         S_DIV: begin
            add_p   = rem_shift;
            add_sub = 1'b1;
         end
         S_FIX: begin
            add_p   = '0;
            add_q   = fixq_ff ? z_ff : x_ff;
            add_sub = 1'b1;
         end
         default: begin
            add_p = x_ff;
         end
      endcase
   end

   assign add_sum = {1'b0, add_p}
                  + (add_sub ? ~{1'b0, add_q} : {1'b0, add_q})
                  + {{WORD_BITS{1'b0}}, add_sub};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      na_in    = na_ff;
      nb_in    = nb_ff;
      fixq_in  = fixq_ff;
      ctl_in   = ctl_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl_in  = in_ctl;
               a_in    = in_a;
               b_in    = in_b;
               x_in    = '0;
               y_in    = in_b;
               z_in    = '0;
               na_in   = in_a[WORD_BITS-1];
               nb_in   = in_b[WORD_BITS-1];
               fixq_in = 1'b1;
               cnt_in  = CNT_BITS'(WORD_BITS - 1);
               if (in_ctl.status != ST_OK) begin
                  state_in = S_DONE;
               end else begin
                  case (in_ctl.opcode)
                     OP_MUL: begin
                        y_in     = in_a;
                        z_in     = in_b;
                        state_in = S_MUL;
                     end
                     OP_DIV: begin
                        z_in = in_a;
                        if (in_b == '0) begin
                           ctl_in.status = ST_DIV_ZERO;
                           z_in          = '0;
                           state_in      = S_DONE;
                        end else begin
                           state_in = S_ABSA;
                        end
                     end
                     default: begin
                        x_in     = in_a;
                        state_in = S_ADDSUB;
                     end
                  endcase
               end
            end
         end
         S_ADDSUB: begin
            z_in     = add_sum[WORD_BITS-1:0];
            x_in     = '0;
            state_in = S_DONE;
         end
         S_MUL: begin
            if (z_ff[0]) begin
               x_in = add_sum[WORD_BITS-1:0];
            end
            y_in = y_ff << 1;
            z_in = z_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_ABSA: begin
            if (na_ff) begin
               z_in = add_sum[WORD_BITS-1:0];
            end
            state_in = S_ABSB;
         end
         S_ABSB: begin
            if (nb_ff) begin
               y_in = add_sum[WORD_BITS-1:0];
            end
            state_in = S_DIV;
         end
         S_DIV: begin
            x_in   = add_sum[WORD_BITS] ? rem_shift : add_sum[WORD_BITS-1:0];
            z_in   = {z_ff[WORD_BITS-2:0], ~add_sum[WORD_BITS]};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            if (fixq_ff) begin
               if (na_ff != nb_ff) begin
                  z_in = add_sum[WORD_BITS-1:0];
               end
               fixq_in = 1'b0;
            end else begin
               if (na_ff) begin
                  x_in = add_sum[WORD_BITS-1:0];
               end
               state_in = S_DONE;
            end
         end
         default: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      na_ff   <= na_in;
      nb_ff   <= nb_in;
      fixq_ff <= fixq_in;
      ctl_ff  <= ctl_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res_ctl   = ctl_ff;
   assign res_a     = a_ff;
   assign res_b     = b_ff;
   assign res_ans   = (ctl_ff.opcode == OP_MUL) ? x_ff : z_ff;
   assign res_rem   = (ctl_ff.opcode == OP_DIV) ? x_ff : '0;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff != S_IDLE) |=> (state_ff != S_IDLE))
      else $error("arithmetic unit lost its job on a start while busy");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && ctl_ff.status != ST_OK) |-> (res_ans == '0 && res_rem == '0))
      else $error("error result carries a nonzero answer or remainder");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (x_ff < y_ff))
      else $error("partial remainder not below divisor");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !res_take) |=> (state_ff == S_DONE && $stable(res_ans)))
      else $error("finished result changed before it was taken");

endmodule

@@ rtl/core/ascii_infix_integer_calculator_top.sv @@
// Top level of the ASCII infix integer calculator.
// A character item is taken whenever the arithmetic unit is idle. The
// end-of-line item hands the parsed line to a sequenced arithmetic unit built
// around one shared adder, and the block takes no item until that unit is
// free again: quit and invalid-operator lines go straight to the result, add
// and subtract use the adder once, multiply and divide shift and add or
// subtract over each bit. One finished result can wait in the output register
// while the next line is read and computed.
module ascii_infix_integer_calculator_top #(
   parameter int WORD_BITS = acalc_pkg::ACALC_WORD_BITS
) (
   input  logic   clock,
   input  logic   reset,
   acalc_req_if.sink   req_chan,
   acalc_rsp_if.source rsp_chan
);
   import acalc_pkg::*;

   logic                 alu_idle;
   logic                 char_take;
   logic                 line_end;
   acalc_ctl_type        job_ctl;
   logic [WORD_BITS-1:0] job_a;
   logic [WORD_BITS-1:0] job_b;

   logic                 res_valid;
   logic                 res_take;
   acalc_ctl_type        res_ctl;
   logic [WORD_BITS-1:0] res_a;
   logic [WORD_BITS-1:0] res_b;
   logic [WORD_BITS-1:0] res_ans;
   logic [WORD_BITS-1:0] res_rem;

   logic                 rsp_valid_ff, rsp_valid_in;
   acalc_ctl_type        rsp_ctl_ff;
   logic [OUT_BITS-1:0]  rsp_a_ff;
   logic [OUT_BITS-1:0]  rsp_b_ff;
   logic [OUT_BITS-1:0]  rsp_ans_ff;
   logic [OUT_BITS-1:0]  rsp_rem_ff;

   function automatic logic [OUT_BITS-1:0] to_out(input logic [WORD_BITS-1:0] v);
      logic [OUT_BITS-1:0] r;
      for (int i = 0; i < OUT_BITS; i++) begin
         r[i] = v[(i < WORD_BITS) ? i : WORD_BITS - 1];
      end
      return r;
   endfunction

   assign req_chan.ready = alu_idle;
   assign char_take = req_chan.valid && alu_idle && !req_chan.end_of_line;
   assign line_end  = req_chan.valid && alu_idle && req_chan.end_of_line;

   acalc_parser #(
      .WORD_BITS (WORD_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .char_take (char_take),
      .line_end  (line_end),
      .char_code (req_chan.char_code),
      .job_ctl   (job_ctl),
      .job_a     (job_a),
      .job_b     (job_b)
   );

   acalc_alu #(
      .WORD_BITS (WORD_BITS)
   ) u_alu (
      .clock     (clock),
      .reset     (reset),
      .start     (line_end),
      .in_ctl    (job_ctl),
      .in_a      (job_a),
      .in_b      (job_b),
      .idle      (alu_idle),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_ctl   (res_ctl),
      .res_a     (res_a),
      .res_b     (res_b),
      .res_ans   (res_ans),
      .res_rem   (res_rem)
   );

   assign res_take     = res_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_valid_in = res_take || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_take) begin
         rsp_ctl_ff <= res_ctl;
         rsp_a_ff   <= to_out(res_a);
         rsp_b_ff   <= to_out(res_b);
         rsp_ans_ff <= to_out(res_ans);
         rsp_rem_ff <= to_out(res_rem);
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_ctl_ff.status;
   assign rsp_chan.operator_code   = rsp_ctl_ff.opcode;
   assign rsp_chan.first_operand   = rsp_a_ff;
   assign rsp_chan.second_operand  = rsp_b_ff;
   assign rsp_chan.answer          = rsp_ans_ff;
   assign rsp_chan.remainder_value = rsp_rem_ff;

endmodule

@@ dv/tb_ascii_infix_integer_calculator_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the ASCII infix integer calculator top level.
module tb_ascii_infix_integer_calculator_top;
   import acalc_pkg::*;

   typedef enum logic [3:0] {
      PS_START, PS_A_SIGN, PS_A_AFTER, PS_A_DIGITS, PS_OP_WAIT, PS_BAD_OP, PS_QUIT,
      PS_B_START, PS_B_SIGN, PS_B_AFTER, PS_B_DIGITS, PS_DONE
   } parse_state_type;

   typedef struct {
      logic [1:0]  status;
      logic [1:0]  opcode;
      logic [31:0] first_num;
      logic [31:0] second_num;
      logic [31:0] answer;
      logic [31:0] remainder;
   } calc_result_type;

   logic clock;
   logic reset;

   acalc_req_if req_bus ();
   acalc_rsp_if rsp_bus ();

   ascii_infix_integer_calculator_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   parse_state_type line_state;
   logic [31:0]     held_first;
   logic [31:0]     digit_acc;
   logic            minus_seen;
   logic [1:0]      held_op;

   calc_result_type pending_results[$];
   calc_result_type oldest_result;
   logic [7:0]      line_text[$];
   int              mismatch_count;
   int              items_sent;
   int              burst_left;
   bit              hold_off_req;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic [31:0] signed_number();
      return minus_seen ? 32'd0 - digit_acc : digit_acc;
   endfunction

   function automatic void clear_number();
      digit_acc  = '0;
      minus_seen = 1'b0;
   endfunction

   function automatic void clear_line();
      line_state = PS_START;
      held_first = '0;
      held_op    = OP_ADD;
      clear_number();
   endfunction

   function automatic void take_digit(logic [7:0] c);
      digit_acc = digit_acc * 32'd10 + 32'(c - CH_ZERO);
   endfunction

   function automatic void parse_char(logic [7:0] c);
      bit retry;
      retry = 1'b1;
      while (retry) begin
         retry = 1'b0;
         case (line_state)
            PS_START: begin
               if (!is_blank(c)) begin
                  if (c == CH_Q_LOW || c == CH_Q_UP || c == CH_NUL) begin
                     line_state = PS_QUIT;
                  end else begin
                     clear_number();
                     line_state = PS_A_SIGN;
                     retry = 1'b1;
                  end
               end
            end
            PS_A_SIGN, PS_B_SIGN: begin
               line_state = (line_state == PS_A_SIGN) ? PS_A_AFTER : PS_B_AFTER;
               if (c == CH_MINUS) minus_seen = 1'b1;
               else if (c != CH_PLUS) retry = 1'b1;
            end
            PS_A_AFTER: begin
               if (is_digit(c)) begin
                  take_digit(c);
                  line_state = PS_A_DIGITS;
               end else begin
                  held_first = '0;
                  line_state = PS_OP_WAIT;
                  retry = 1'b1;
               end
            end
            PS_A_DIGITS: begin
               if (is_digit(c)) begin
                  take_digit(c);
               end else begin
                  held_first = signed_number();
                  line_state = PS_OP_WAIT;
                  retry = 1'b1;
               end
            end
            PS_OP_WAIT: begin
               if (!is_blank(c)) begin
                  line_state = PS_B_START;
                  case (c)
                     CH_PLUS:  held_op = OP_ADD;
                     CH_MINUS: held_op = OP_SUB;
                     CH_STAR:  held_op = OP_MUL;
                     CH_SLASH: held_op = OP_DIV;
                     default:  line_state = PS_BAD_OP;
                  endcase
                  if (line_state == PS_B_START) clear_number();
               end
            end
            PS_B_START: begin
               if (!is_blank(c)) begin
                  line_state = PS_B_SIGN;
                  retry = 1'b1;
               end
            end
            PS_B_AFTER: begin
               if (is_digit(c)) begin
                  take_digit(c);
                  line_state = PS_B_DIGITS;
               end else begin
                  clear_number();
                  line_state = PS_DONE;
               end
            end
            PS_B_DIGITS: begin
               if (is_digit(c)) begin
                  take_digit(c);
               end else begin
                  digit_acc  = signed_number();
                  minus_seen = 1'b0;
                  line_state = PS_DONE;
               end
            end
            default: ;
         endcase
      end
   endfunction

   function automatic calc_result_type evaluate_line();
      calc_result_type res;
      logic [31:0]     ua, ub, quo, rem;
      res = '{ST_OK, OP_ADD, '0, '0, '0, '0};
      case (line_state)
         PS_START, PS_QUIT: res.status = ST_QUIT;
         PS_A_SIGN, PS_A_AFTER, PS_A_DIGITS: begin
            res.status    = ST_BAD_OP;
            res.first_num = signed_number();
         end
         PS_OP_WAIT, PS_BAD_OP: begin
            res.status    = ST_BAD_OP;
            res.first_num = held_first;
         end
         default: begin
            res.first_num  = held_first;
            res.second_num = signed_number();
            res.opcode     = held_op;
            case (held_op)
               OP_ADD: res.answer = res.first_num + res.second_num;
               OP_SUB: res.answer = res.first_num - res.second_num;
               OP_MUL: res.answer = res.first_num * res.second_num;
               default: begin
                  if (res.second_num == 0) begin
                     res.status = ST_DIV_ZERO;
                  end else begin
                     ua  = res.first_num[31] ? 32'd0 - res.first_num : res.first_num;
                     ub  = res.second_num[31] ? 32'd0 - res.second_num : res.second_num;
                     quo = ua / ub;
                     rem = ua % ub;
                     res.answer    = (res.first_num[31] != res.second_num[31]) ?
                                     32'd0 - quo : quo;
                     res.remainder = res.first_num[31] ? 32'd0 - rem : rem;
                  end
               end
            endcase
         end
      endcase
      clear_line();
      return res;
   endfunction

   function automatic void check_field(string label, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %08h, got %08h", $realtime, label, want_v,
                     got_v);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result arrived with nothing expected, answer %08h", $realtime,
                        rsp_bus.answer);
         end else begin
            oldest_result = pending_results.pop_front();
            check_field("status", 32'(oldest_result.status), 32'(rsp_bus.status));
            check_field("operator_code", 32'(oldest_result.opcode),
                        32'(rsp_bus.operator_code));
            check_field("first_operand", oldest_result.first_num, rsp_bus.first_operand);
            check_field("second_operand", oldest_result.second_num, rsp_bus.second_operand);
            check_field("answer", oldest_result.answer, rsp_bus.answer);
            check_field("remainder_value", oldest_result.remainder, rsp_bus.remainder_value);
         end
      end
   end

   // The receiver changes its stall pattern every so often; a requested hold-off
   // keeps ready low long enough for the block to fill and stall its input.
   initial begin
      int mode;
      int mode_left;
      int tick;
      rsp_bus.ready = 1'b0;
      mode = 0;
      mode_left = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_bus.ready = 1'b0;
            repeat (300) @(negedge clock);
            hold_off_req = 1'b0;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(30, 150);
         end
         mode_left--;
         tick++;
         case (mode)
            0: rsp_bus.ready = 1'b1;
            1: rsp_bus.ready = 1'($urandom_range(0, 1));
            2: rsp_bus.ready = (tick % 3) != 0;
            default: rsp_bus.ready = ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic send_item(logic [7:0] c, bit eol);
      if (burst_left == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(5, 15) : $urandom_range(0, 3))
            @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_bus.valid       = 1'b1;
      req_bus.char_code   = c;
      req_bus.end_of_line = eol;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      if (eol) pending_results.push_back(evaluate_line());
      else parse_char(c);
      @(negedge clock);
   endtask

   task automatic send_line();
      foreach (line_text[i]) send_item(line_text[i], 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_text(string s);
      line_text.delete();
      foreach (s[i]) line_text.push_back(s[i]);
      send_line();
   endtask

   function automatic logic [7:0] random_char();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(0, 255));
         1: return 8'(CH_ZERO + $urandom_range(0, 9));
         2: begin
            case ($urandom_range(0, 5))
               0: return CH_PLUS;
               1: return CH_MINUS;
               2: return CH_STAR;
               3: return CH_SLASH;
               4: return CH_SPACE;
               default: return CH_TAB;
            endcase
         end
         default: begin
            case ($urandom_range(0, 2))
               0: return CH_Q_LOW;
               1: return CH_Q_UP;
               default: return CH_NUL;
            endcase
         end
      endcase
   endfunction

   function automatic void add_blanks();
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
         line_text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
   endfunction

   function automatic void add_decimal(logic [31:0] mag);
      string s;
      s = $sformatf("%0d", mag);
      foreach (s[i]) line_text.push_back(s[i]);
   endfunction

   function automatic void add_number();
      int kind;
      case ($urandom_range(0, 3))
         2: line_text.push_back(CH_MINUS);
         3: line_text.push_back(CH_PLUS);
         default: ;
      endcase
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2: add_decimal($urandom_range(0, 99));
         3, 4, 5: add_decimal($urandom);
         6: begin
            case ($urandom_range(0, 4))
               0: add_decimal(32'h8000_0000);
               1: add_decimal(32'h7FFF_FFFF);
               2: add_decimal(32'hFFFF_FFFF);
               3: add_decimal(32'd0);
               default: add_decimal(32'd1);
            endcase
         end
         7: repeat ($urandom_range(11, 24))
               line_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
         8: ;
         default: add_decimal($urandom_range(0, 9999));
      endcase
   endfunction

   function automatic void build_random_line();
      int kind;
      line_text.delete();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         add_blanks();
         add_number();
         add_blanks();
         case ($urandom_range(0, 16))
            0, 1, 2, 3: line_text.push_back(CH_PLUS);
            4, 5, 6, 7: line_text.push_back(CH_MINUS);
            8, 9, 10, 11: line_text.push_back(CH_STAR);
            12, 13, 14, 15: line_text.push_back(CH_SLASH);
            default: line_text.push_back(random_char());
         endcase
         add_blanks();
         add_number();
         repeat ($urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : 0)
            line_text.push_back(random_char());
      end else if (kind < 76) begin
         add_blanks();
         line_text.push_back($urandom_range(0, 1) ? CH_Q_LOW : CH_Q_UP);
         repeat ($urandom_range(0, 3)) line_text.push_back(random_char());
      end else if (kind < 80) begin
         add_blanks();
      end else if (kind < 85) begin
         // Most negative value divided or multiplied by minus one.
         if ($urandom_range(0, 1)) line_text.push_back(CH_MINUS);
         add_decimal(32'h8000_0000);
         add_blanks();
         line_text.push_back($urandom_range(0, 2) != 0 ? CH_SLASH : CH_STAR);
         add_blanks();
         line_text.push_back(CH_MINUS);
         add_decimal(32'd1);
      end else if (kind < 91) begin
         add_blanks();
         add_number();
         add_blanks();
         if ($urandom_range(0, 1)) line_text.push_back(CH_NUL);
      end else begin
         repeat ($urandom_range(1, 8)) line_text.push_back(random_char());
      end
      if ($urandom_range(0, 11) == 0 && line_text.size() > 0)
         line_text[$urandom_range(0, line_text.size() - 1)] = CH_NUL;
   endfunction

   task automatic test_operations();
      send_text("9+-1");
      send_text("2-7");
      send_text("-3*5");
      send_text("-8/3");
   endtask

   task automatic test_status_codes();
      send_text("7/0");
      send_text("Q");
      send_text("");
   endtask

   task automatic test_random_lines(int item_goal);
      while (items_sent < item_goal) begin
         build_random_line();
         send_line();
      end
   endtask

   task automatic test_output_backpressure();
      hold_off_req = 1'b1;
      repeat (6) begin
         build_random_line();
         send_line();
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.char_code    = '0;
      req_bus.end_of_line  = 1'b0;
      hold_off_req         = 1'b0;
      mismatch_count       = 0;
      items_sent           = 0;
      burst_left           = 0;
      clear_line();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_operations();
      test_status_codes();
      test_random_lines(420);
      test_output_backpressure();
      test_random_lines(840);

      req_bus.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
